### rtl/core/cmdtok_pkg.sv
// ----------------------------------------------------------------------------
// Command-line tokenizer package
// Shared constants, result records and keyword table for the tokenizer.
// ----------------------------------------------------------------------------
package cmdtok_pkg;

    localparam int MAX_KEYWORD_LEN = 9;
    localparam int POSITION_BITS   = 16;
    localparam int WLEN_BITS       = $clog2(MAX_KEYWORD_LEN + 1);
    localparam int START_W         = 16;
    localparam int NUM_KEYWORDS    = 26;
    localparam int KW_CHARS        = 9;
    localparam int KW_TEXT_W       = KW_CHARS * 8;
    localparam int GROUP_MAX       = 3;
    localparam int QDEPTH          = 4;
    localparam int QA_BITS         = $clog2(QDEPTH);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic [3:0] TT_KEYWORD = 4'd0;
    localparam logic [3:0] TT_IDENT   = 4'd1;
    localparam logic [3:0] TT_STRING  = 4'd2;
    localparam logic [3:0] TT_FLAG    = 4'd3;
    localparam logic [3:0] TT_DOT     = 4'd4;
    localparam logic [3:0] TT_DOTDOT  = 4'd5;
    localparam logic [3:0] TT_SLASH   = 4'd6;
    localparam logic [3:0] TT_WILD    = 4'd7;
    localparam logic [3:0] TT_UNKNOWN = 4'd8;
    localparam logic [3:0] TT_END     = 4'd9;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_WORD = 6'b000010,
        M_STR  = 6'b000100,
        M_ESC  = 6'b001000,
        M_FLAG = 6'b010000,
        M_DOT  = 6'b100000
    } t_mode;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value_byte;
        logic [3:0]  token_type;
        logic [15:0] start_pos;
        logic [4:0]  keyword_index;
    } t_result;

    typedef struct packed {
        logic [1:0]                    cnt;
        t_result [GROUP_MAX-1:0]       res;
    } t_group;

    typedef logic [MAX_KEYWORD_LEN-1:0][7:0] t_wbuf;

    typedef struct packed {
        logic [3:0]           len;
        logic [KW_TEXT_W-1:0] text;
    } t_kw;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } t_kw_hit;

    function automatic t_result mk_value(input logic [7:0] b);
        t_result r;
        r            = '0;
        r.kind       = KIND_VALUE;
        r.value_byte = b;
        return r;
    endfunction

    function automatic t_result mk_end(input logic [3:0] tt, input logic [15:0] start,
                                       input logic [4:0] kwi);
        t_result r;
        r               = '0;
        r.kind          = KIND_END;
        r.token_type    = tt;
        r.start_pos     = start;
        r.keyword_index = kwi;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_word_char(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == CH_UNDER || b == CH_DOT || b == CH_DASH;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    // Keyword text is right-justified: the last character sits in the low byte.
    function automatic t_kw kw_entry(input logic [4:0] k);
        t_kw e;
        e = '0;
        case (k)
            5'd0:  begin e.len = 4'd6; e.text = KW_TEXT_W'("change");    end
            5'd1:  begin e.len = 4'd2; e.text = KW_TEXT_W'("go");        end
            5'd2:  begin e.len = 4'd8; e.text = KW_TEXT_W'("navigate");  end
            5'd3:  begin e.len = 4'd5; e.text = KW_TEXT_W'("enter");     end
            5'd4:  begin e.len = 4'd4; e.text = KW_TEXT_W'("copy");      end
            5'd5:  begin e.len = 4'd4; e.text = KW_TEXT_W'("move");      end
            5'd6:  begin e.len = 4'd6; e.text = KW_TEXT_W'("delete");    end
            5'd7:  begin e.len = 4'd6; e.text = KW_TEXT_W'("remove");    end
            5'd8:  begin e.len = 4'd6; e.text = KW_TEXT_W'("rename");    end
            5'd9:  begin e.len = 4'd6; e.text = KW_TEXT_W'("create");    end
            5'd10: begin e.len = 4'd4; e.text = KW_TEXT_W'("make");      end
            5'd11: begin e.len = 4'd4; e.text = KW_TEXT_W'("list");      end
            5'd12: begin e.len = 4'd4; e.text = KW_TEXT_W'("show");      end
            5'd13: begin e.len = 4'd9; e.text = KW_TEXT_W'("directory"); end
            5'd14: begin e.len = 4'd6; e.text = KW_TEXT_W'("folder");    end
            5'd15: begin e.len = 4'd4; e.text = KW_TEXT_W'("file");      end
            5'd16: begin e.len = 4'd5; e.text = KW_TEXT_W'("files");     end
            5'd17: begin e.len = 4'd2; e.text = KW_TEXT_W'("to");        end
            5'd18: begin e.len = 4'd4; e.text = KW_TEXT_W'("into");      end
            5'd19: begin e.len = 4'd4; e.text = KW_TEXT_W'("from");      end
            5'd20: begin e.len = 4'd2; e.text = KW_TEXT_W'("as");        end
            5'd21: begin e.len = 4'd4; e.text = KW_TEXT_W'("back");      end
            5'd22: begin e.len = 4'd4; e.text = KW_TEXT_W'("help");      end
            5'd23: begin e.len = 4'd4; e.text = KW_TEXT_W'("exit");      end
            5'd24: begin e.len = 4'd4; e.text = KW_TEXT_W'("quit");      end
            5'd25: begin e.len = 4'd7; e.text = KW_TEXT_W'("current");   end
            default: e = '0;
        endcase
        return e;
    endfunction

    // Parallel compare of the buffered word against every keyword.
    // The list has no duplicates, so at most one entry hits.
    function automatic t_kw_hit kw_lookup(input t_wbuf wbuf, input logic [WLEN_BITS-1:0] wlen);
        t_kw_hit r;
        t_kw     e;
        logic    eq;
        r = '0;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            e  = kw_entry(5'(k));
            eq = (wlen == WLEN_BITS'(e.len)) && (e.len != 4'd0);
            for (int i = 0; i < KW_CHARS; i++) begin
                if (i < int'(e.len)) begin
                    if (wbuf[i] != e.text[(int'(e.len) - 1 - i) * 8 +: 8]) begin
                        eq = 1'b0;
                    end
                end
            end
            if (eq) begin
                r.hit = 1'b1;
                r.idx = 5'(k);
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/cmdtok_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Scanner state machine: classifies each input word and builds the group of
// up to three result records that it causes.
// ----------------------------------------------------------------------------
module cmdtok_front
    import cmdtok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_opcode,
    input  logic [7:0] i_byte_value,
    output t_group     o_group
);

    t_mode                    r_mode,   n_mode;
    logic                     r_dq,     n_dq;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic [POSITION_BITS-1:0] r_tstart, n_tstart;
    logic [WLEN_BITS-1:0]     r_wlen,   n_wlen;
    logic                     r_tl,     n_tl;
    t_wbuf                    r_wbuf;

    logic [POSITION_BITS-1:0] pos_inc;
    t_kw_hit                  kw;
    logic                     close_valid;
    t_result                  close_rec;
    logic [3:0]               close_type;

    t_group                   grp;
    logic [1:0]               cnt;
    logic                     consumed;
    logic                     close_now;
    logic                     app_en;
    logic                     app_fresh;
    logic [WLEN_BITS-1:0]     base_len;
    logic                     base_tl;
    logic                     wr_en;
    logic [WLEN_BITS-1:0]     wr_sel;
    logic [7:0]               wr_data;
    logic [7:0]               quote_ch;

    assign pos_inc  = (r_pos == POS_MAX) ? POS_MAX : r_pos + 1'b1;
    assign kw       = kw_lookup(r_wbuf, r_wlen);
    assign quote_ch = r_dq ? CH_DQUOTE : CH_SQUOTE;

    // End record for whatever token is open when it is closed early.
    always_comb begin
        close_valid = 1'b1;
        close_type  = TT_IDENT;
        unique case (r_mode)
            M_WORD:        close_type  = (kw.hit && !r_tl) ? TT_KEYWORD : TT_IDENT;
            M_STR, M_ESC:  close_type  = TT_STRING;
            M_FLAG:        close_type  = TT_FLAG;
            M_DOT:         close_type  = TT_DOT;
            M_IDLE:        close_valid = 1'b0;
            default:       close_valid = 1'b0;
        endcase
        close_rec = mk_end(close_type, START_W'(r_tstart),
                           (close_type == TT_KEYWORD) ? kw.idx : 5'd0);
    end

    always_comb begin
        n_mode    = r_mode;
        n_dq      = r_dq;
        n_pos     = r_pos;
        n_tstart  = r_tstart;
        n_wlen    = r_wlen;
        n_tl      = r_tl;
        grp       = '0;
        cnt       = 2'd0;
        consumed  = 1'b0;
        close_now = 1'b0;
        app_en    = 1'b0;
        app_fresh = 1'b0;
        base_len  = r_wlen;
        base_tl   = r_tl;
        wr_en     = 1'b0;
        wr_sel    = r_wlen;
        wr_data   = to_lower(i_byte_value);

        if (i_opcode) begin
            if (close_valid) begin
                grp.res[cnt] = close_rec;
                cnt          = cnt + 2'd1;
            end
            grp.res[cnt] = mk_end(TT_END, START_W'(r_pos), 5'd0);
            cnt          = cnt + 2'd1;
            n_mode       = M_IDLE;
            n_dq         = 1'b0;
            n_pos        = '0;
            n_tstart     = '0;
            n_wlen       = '0;
            n_tl         = 1'b0;
        end else begin
            unique case (r_mode)
                M_WORD: begin
                    if (is_word_char(i_byte_value)) begin
                        app_en       = 1'b1;
                        grp.res[cnt] = mk_value(i_byte_value);
                        cnt          = cnt + 2'd1;
                        consumed     = 1'b1;
                    end else begin
                        close_now = 1'b1;
                    end
                end
                M_STR: begin
                    if (i_byte_value == quote_ch) begin
                        grp.res[cnt] = mk_end(TT_STRING, START_W'(r_tstart), 5'd0);
                        cnt          = cnt + 2'd1;
                        n_mode       = M_IDLE;
                    end else if (i_byte_value == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else begin
                        grp.res[cnt] = mk_value(i_byte_value);
                        cnt          = cnt + 2'd1;
                    end
                    consumed = 1'b1;
                end
                M_ESC: begin
                    grp.res[cnt] = mk_value(i_byte_value);
                    cnt          = cnt + 2'd1;
                    n_mode       = M_STR;
                    consumed     = 1'b1;
                end
                M_FLAG: begin
                    if (is_alpha(i_byte_value) || is_digit(i_byte_value)
                            || i_byte_value == CH_DASH) begin
                        grp.res[cnt] = mk_value(i_byte_value);
                        cnt          = cnt + 2'd1;
                        consumed     = 1'b1;
                    end else begin
                        close_now = 1'b1;
                    end
                end
                M_DOT: begin
                    if (i_byte_value == CH_DOT) begin
                        grp.res[cnt] = mk_value(i_byte_value);
                        cnt          = cnt + 2'd1;
                        grp.res[cnt] = mk_end(TT_DOTDOT, START_W'(r_tstart), 5'd0);
                        cnt          = cnt + 2'd1;
                        n_mode       = M_IDLE;
                        consumed     = 1'b1;
                    end else begin
                        close_now = 1'b1;
                    end
                end
                M_IDLE: begin
                    n_mode = M_IDLE;
                end
                default: begin
                    n_mode = M_IDLE;
                end
            endcase

            if (close_now) begin
                grp.res[cnt] = close_rec;
                cnt          = cnt + 2'd1;
                n_mode       = M_IDLE;
            end

            // A byte that did not continue the open token starts a new one.
            if (!consumed) begin
                priority if (is_space(i_byte_value)) begin
                    n_mode = M_IDLE;
                end else if (i_byte_value == CH_DQUOTE || i_byte_value == CH_SQUOTE) begin
                    n_mode   = M_STR;
                    n_dq     = (i_byte_value == CH_DQUOTE);
                    n_tstart = pos_inc;
                end else if (i_byte_value == CH_DASH) begin
                    n_tstart     = r_pos;
                    grp.res[cnt] = mk_value(i_byte_value);
                    cnt          = cnt + 2'd1;
                    n_mode       = M_FLAG;
                end else if (i_byte_value == CH_DOT) begin
                    n_tstart     = r_pos;
                    grp.res[cnt] = mk_value(i_byte_value);
                    cnt          = cnt + 2'd1;
                    n_mode       = M_DOT;
                end else if (i_byte_value == CH_SLASH) begin
                    grp.res[cnt] = mk_value(i_byte_value);
                    cnt          = cnt + 2'd1;
                    grp.res[cnt] = mk_end(TT_SLASH, START_W'(r_pos), 5'd0);
                    cnt          = cnt + 2'd1;
                end else if (i_byte_value == CH_STAR) begin
                    grp.res[cnt] = mk_value(i_byte_value);
                    cnt          = cnt + 2'd1;
                    grp.res[cnt] = mk_end(TT_WILD, START_W'(r_pos), 5'd0);
                    cnt          = cnt + 2'd1;
                end else if (is_alpha(i_byte_value) || i_byte_value == CH_UNDER) begin
                    n_tstart     = r_pos;
                    app_en       = 1'b1;
                    app_fresh    = 1'b1;
                    grp.res[cnt] = mk_value(i_byte_value);
                    cnt          = cnt + 2'd1;
                    n_mode       = M_WORD;
                end else begin
                    grp.res[cnt] = mk_value(i_byte_value);
                    cnt          = cnt + 2'd1;
                    grp.res[cnt] = mk_end(TT_UNKNOWN, START_W'(r_pos), 5'd0);
                    cnt          = cnt + 2'd1;
                end
            end

            n_pos = pos_inc;
        end

        // Word buffer append; a word that overflows the buffer is never a keyword.
        if (app_en) begin
            base_len = app_fresh ? '0 : r_wlen;
            base_tl  = app_fresh ? 1'b0 : r_tl;
            n_wlen   = base_len;
            n_tl     = base_tl;
            if (!base_tl) begin
                if (base_len < WLEN_BITS'(MAX_KEYWORD_LEN)) begin
                    wr_en  = 1'b1;
                    wr_sel = base_len;
                    n_wlen = base_len + 1'b1;
                end else begin
                    n_tl = 1'b1;
                end
            end
        end

        grp.cnt = cnt;
    end

    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_dq     <= 1'b0;
            r_pos    <= '0;
            r_tstart <= '0;
            r_wlen   <= '0;
            r_tl     <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_dq     <= n_dq;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_wlen   <= n_wlen;
            r_tl     <= n_tl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
            if (i_accept && wr_en && wr_sel == WLEN_BITS'(i)) begin
                r_wbuf[i] <= wr_data;
            end
        end
    end

endmodule

### rtl/core/cmdtok_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer group queue
// Short FIFO of result groups between the scanner and the output serializer.
// ----------------------------------------------------------------------------
module cmdtok_queue
    import cmdtok_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output t_group o_head,
    output logic   o_full,
    output logic   o_empty
);

    t_group             r_mem [QDEPTH];
    logic [QA_BITS-1:0] r_wp, n_wp;
    logic [QA_BITS-1:0] r_rp, n_rp;
    logic [QA_BITS:0]   r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (QA_BITS + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_group;
        end
    end

endmodule

### rtl/core/cmdtok_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Walks the head group of the queue and presents its records one at a time.
// ----------------------------------------------------------------------------
module cmdtok_back
    import cmdtok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_group      i_head,
    input  logic        i_q_empty,
    input  logic        i_pop,
    output logic        o_q_pop,
    output logic        o_kind,
    output logic [7:0]  o_value_byte,
    output logic [3:0]  o_token_type,
    output logic [15:0] o_start_pos,
    output logic [4:0]  o_keyword_index,
    output logic        o_last
);

    logic [1:0] r_idx, n_idx;
    t_result    rec;
    logic       at_last;
    logic       take;

    assign rec     = i_head.res[r_idx];
    assign at_last = (r_idx == i_head.cnt - 2'd1);
    assign take    = i_pop && !i_q_empty;

    // The group leaves the queue together with its final record.
    assign o_q_pop = take && at_last;

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

    assign o_kind          = rec.kind;
    assign o_value_byte    = rec.value_byte;
    assign o_token_type    = rec.token_type;
    assign o_start_pos     = rec.start_pos;
    assign o_keyword_index = rec.keyword_index;
    assign o_last          = at_last;

endmodule

### rtl/core/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Command-line tokenizer
// Splits a byte stream into words, keywords, strings, flags and punctuation.
//
//   Channel  | Handshake          | Words
//   ---------+--------------------+-------------------------------------------
//   input    | push / full        | i_opcode, i_byte_value
//   result   | empty / pop        | o_kind, o_value_byte, o_token_type,
//            |                    | o_start_pos, o_keyword_index, o_last
//
// The scanner takes one input word per cycle while full is low; its records,
// if any (up to three), are queued as one group in a four-group FIFO and leave
// one record per cycle while pop is high. Reset is synchronous and clears the
// scanner state and the FIFO; the keyword buffer is not cleared. full rises
// only when the FIFO holds four groups, so a slow reader stalls the input
// after four queued groups.
// ----------------------------------------------------------------------------
module command_line_tokenizer
    import cmdtok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [7:0]  i_byte_value,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_value_byte,
    output logic [3:0]  o_token_type,
    output logic [15:0] o_start_pos,
    output logic [4:0]  o_keyword_index,
    output logic        o_last
);

    logic   accept;
    t_group front_group;
    t_group head_group;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    assign full   = q_full;
    assign empty  = q_empty;
    assign accept = push && !q_full;

    cmdtok_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_byte_value (i_byte_value),
        .o_group      (front_group)
    );

    // Items that produce no records never enter the queue.
    cmdtok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && front_group.cnt != 2'd0),
        .i_group (front_group),
        .i_pop   (q_pop),
        .o_head  (head_group),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cmdtok_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_group),
        .i_q_empty       (q_empty),
        .i_pop           (pop),
        .o_q_pop         (q_pop),
        .o_kind          (o_kind),
        .o_value_byte    (o_value_byte),
        .o_token_type    (o_token_type),
        .o_start_pos     (o_start_pos),
        .o_keyword_index (o_keyword_index),
        .o_last          (o_last)
    );

endmodule

### rtl/core/cmdtok_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top-level ports and flags malformed or unstable result records.
// ----------------------------------------------------------------------------
module cmdtok_checker
    import cmdtok_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        i_opcode,
    input logic [7:0]  i_byte_value,
    input logic        empty,
    input logic        pop,
    input logic        o_kind,
    input logic [7:0]  o_value_byte,
    input logic [3:0]  o_token_type,
    input logic [15:0] o_start_pos,
    input logic [4:0]  o_keyword_index,
    input logic        o_last
);

    // A waiting record must not change until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kind) && $stable(o_value_byte)
            && $stable(o_token_type) && $stable(o_start_pos)
            && $stable(o_keyword_index) && $stable(o_last))
        else $error("result record changed while stalled");

    // Value records carry only the character.
    a_value_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_VALUE |->
            o_token_type == '0 && o_start_pos == '0 && o_keyword_index == '0)
        else $error("value record carries end-record fields");

    // End records have no character, a legal type, and an index only for keywords.
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_END |->
            o_value_byte == '0 && o_token_type <= TT_END
            && (o_token_type == TT_KEYWORD || o_keyword_index == '0))
        else $error("malformed token end record");

    // The queue can only fill up right after an accepted input word.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an input push");

endmodule

bind command_line_tokenizer cmdtok_checker u_cmdtok_checker (.*);

### tb/command_line_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// Command-line tokenizer checker
// Watches both queue interfaces of the tokenizer, predicts the records that
// every accepted input word causes, and compares each popped record with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module command_line_tokenizer_checker
    import cmdtok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic        empty,
    input  logic        pop,
    input  logic        o_kind,
    input  logic [7:0]  o_value_byte,
    input  logic [3:0]  o_token_type,
    input  logic [15:0] o_start_pos,
    input  logic [4:0]  o_keyword_index,
    input  logic        o_last,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_results_checked,
    output logic [NUM_KEYWORDS-1:0] o_keywords_seen
);

    typedef struct packed {
        logic        kind;
        logic [7:0]  value_byte;
        logic [3:0]  token_type;
        logic [15:0] start_pos;
        logic [4:0]  keyword_index;
        logic        last;
    } token_rec_t;

    string keywords [NUM_KEYWORDS] = '{
        "change", "go", "navigate", "enter",
        "copy", "move", "delete", "remove", "rename", "create",
        "make", "list", "show",
        "directory", "folder", "file", "files",
        "to", "into", "from", "as", "back",
        "help", "exit", "quit", "current"
    };

    token_rec_t expected_q[$];
    token_rec_t step_q[$];

    t_mode                    scan;
    logic                     dquote;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] tok_start;
    logic [7:0]               word_text [MAX_KEYWORD_LEN];
    int                       word_len;
    logic                     word_overflow;

    int                       fail_count = 0;
    int                       results_checked = 0;
    logic [NUM_KEYWORDS-1:0]  keywords_seen = '0;

    assign o_fail_count      = fail_count;
    assign o_results_checked = results_checked;
    assign o_keywords_seen   = keywords_seen;

    function automatic logic letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic blank(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_next(input logic [POSITION_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function void clear_scanner();
        scan          = M_IDLE;
        dquote        = 1'b0;
        pos           = '0;
        tok_start     = '0;
        word_len      = 0;
        word_overflow = 1'b0;
    endfunction

    function void add_value(input logic [7:0] b);
        token_rec_t r;
        r            = '0;
        r.kind       = KIND_VALUE;
        r.value_byte = b;
        step_q       = {step_q, r};
    endfunction

    function void add_end(input logic [3:0] tt, input logic [POSITION_BITS-1:0] start,
                          input logic [4:0] kwi);
        token_rec_t r;
        r               = '0;
        r.kind          = KIND_END;
        r.token_type    = tt;
        r.start_pos     = 16'(start);
        r.keyword_index = kwi;
        step_q          = {step_q, r};
    endfunction

    // The buffer holds lowercase text, so the compare is case-insensitive.
    function automatic int keyword_of_word();
        logic same;
        if (word_overflow) return -1;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (keywords[k].len() == word_len) begin
                same = 1'b1;
                for (int i = 0; i < word_len; i++) begin
                    if (keywords[k][i] != word_text[i]) same = 1'b0;
                end
                if (same) return k;
            end
        end
        return -1;
    endfunction

    function void word_push(input logic [7:0] b);
        logic [7:0] c;
        c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (!word_overflow) begin
            if (word_len < MAX_KEYWORD_LEN) begin
                word_text[word_len] = c;
                word_len++;
            end else begin
                word_overflow = 1'b1;
            end
        end
    endfunction

    function void close_open_token();
        int k;
        case (scan)
            M_WORD: begin
                k = keyword_of_word();
                if (k >= 0) add_end(TT_KEYWORD, tok_start, 5'(k));
                else add_end(TT_IDENT, tok_start, '0);
            end
            M_STR, M_ESC: add_end(TT_STRING, tok_start, '0);
            M_FLAG:       add_end(TT_FLAG, tok_start, '0);
            M_DOT:        add_end(TT_DOT, tok_start, '0);
            default: ;
        endcase
        scan = M_IDLE;
    endfunction

    function void open_token(input logic [7:0] b);
        if (blank(b)) return;
        if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            scan      = M_STR;
            dquote    = (b == CH_DQUOTE);
            tok_start = pos_next(pos);
        end else if (b == CH_DASH) begin
            tok_start = pos;
            add_value(b);
            scan = M_FLAG;
        end else if (b == CH_DOT) begin
            tok_start = pos;
            add_value(b);
            scan = M_DOT;
        end else if (b == CH_SLASH) begin
            add_value(b);
            add_end(TT_SLASH, pos, '0);
        end else if (b == CH_STAR) begin
            add_value(b);
            add_end(TT_WILD, pos, '0);
        end else if (letter(b) || b == CH_UNDER) begin
            tok_start     = pos;
            word_len      = 0;
            word_overflow = 1'b0;
            word_push(b);
            add_value(b);
            scan = M_WORD;
        end else begin
            add_value(b);
            add_end(TT_UNKNOWN, pos, '0);
        end
    endfunction

    function void predict(input logic end_mark, input logic [7:0] b);
        logic taken;
        taken = 1'b0;
        step_q.delete();
        if (end_mark) begin
            close_open_token();
            add_end(TT_END, pos, '0);
            clear_scanner();
        end else begin
            case (scan)
                M_WORD: begin
                    if (letter(b) || numeral(b) || b == CH_UNDER || b == CH_DOT
                            || b == CH_DASH) begin
                        word_push(b);
                        add_value(b);
                        taken = 1'b1;
                    end else begin
                        close_open_token();
                    end
                end
                M_STR: begin
                    if (b == (dquote ? CH_DQUOTE : CH_SQUOTE)) begin
                        add_end(TT_STRING, tok_start, '0);
                        scan = M_IDLE;
                    end else if (b == CH_BSLASH) begin
                        scan = M_ESC;
                    end else begin
                        add_value(b);
                    end
                    taken = 1'b1;
                end
                M_ESC: begin
                    // The escaped byte is taken literally, quote or backslash alike.
                    add_value(b);
                    scan  = M_STR;
                    taken = 1'b1;
                end
                M_FLAG: begin
                    if (letter(b) || numeral(b) || b == CH_DASH) begin
                        add_value(b);
                        taken = 1'b1;
                    end else begin
                        close_open_token();
                    end
                end
                M_DOT: begin
                    if (b == CH_DOT) begin
                        add_value(b);
                        add_end(TT_DOTDOT, tok_start, '0);
                        scan  = M_IDLE;
                        taken = 1'b1;
                    end else begin
                        close_open_token();
                    end
                end
                default: scan = M_IDLE;
            endcase
            if (!taken) open_token(b);
            pos = pos_next(pos);
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].last = 1'b1;
        end
        expected_q = {expected_q, step_q};
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        token_rec_t want;
        if (!i_rst_n) begin
            clear_scanner();
            expected_q.delete();
        end else begin
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected: kind %0d, type %0d, value %0d",
                           o_kind, o_token_type, o_value_byte);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(o_kind));
                    compare_field("value_byte", 32'(want.value_byte), 32'(o_value_byte));
                    compare_field("token_type", 32'(want.token_type), 32'(o_token_type));
                    compare_field("start_pos", 32'(want.start_pos), 32'(o_start_pos));
                    compare_field("keyword_index", 32'(want.keyword_index),
                                  32'(o_keyword_index));
                    compare_field("last", 32'(want.last), 32'(o_last));
                    results_checked++;
                    if (want.kind == KIND_END && want.token_type == TT_KEYWORD)
                        keywords_seen[want.keyword_index] = 1'b1;
                end
            end
            if (push && !full) predict(i_opcode, i_byte_value);
        end
        o_pending <= expected_q.size();
    end

endmodule

### tb/tb_command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Command-line tokenizer testbench
// Drives directed and random command lines into the tokenizer with bursty
// input and a stalling reader, and reports the verdict from the checker's
// failure count.
// ----------------------------------------------------------------------------
module tb_command_line_tokenizer;
    import cmdtok_pkg::*;

    localparam logic OP_DATA       = 1'b0;
    localparam logic OP_END        = 1'b1;
    localparam int   RANDOM_ITEMS  = 450;
    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   SETTLE_CYCLES = 10;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        i_opcode     = 1'b0;
    logic [7:0]  i_byte_value = 8'h00;
    logic        pop          = 1'b0;
    logic        full;
    logic        empty;
    logic        o_kind;
    logic [7:0]  o_value_byte;
    logic [3:0]  o_token_type;
    logic [15:0] o_start_pos;
    logic [4:0]  o_keyword_index;
    logic        o_last;

    int                      pending;
    int                      fail_count;
    int                      results_checked;
    logic [NUM_KEYWORDS-1:0] keywords_seen;

    int cycle_count  = 0;
    int words_sent   = 0;
    int blanks_sent  = 0;
    int end_markers  = 0;
    int burst_left   = 0;
    bit gaps_on      = 1'b1;
    int pop_style    = 0;
    int pop_phase    = 0;
    int pop_tick     = 0;

    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.-";
    string flag_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
    string odd_chars  = "!#$%&()+,:;<=>?@[]^`{|}~0123456789";

    always #10 i_clk = ~i_clk;

    command_line_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_byte_value    (i_byte_value),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_value_byte    (o_value_byte),
        .o_token_type    (o_token_type),
        .o_start_pos     (o_start_pos),
        .o_keyword_index (o_keyword_index),
        .o_last          (o_last)
    );

    command_line_tokenizer_checker u_monitor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_opcode          (i_opcode),
        .i_byte_value      (i_byte_value),
        .empty             (empty),
        .pop               (pop),
        .o_kind            (o_kind),
        .o_value_byte      (o_value_byte),
        .o_token_type      (o_token_type),
        .o_start_pos       (o_start_pos),
        .o_keyword_index   (o_keyword_index),
        .o_last            (o_last),
        .o_pending         (pending),
        .o_fail_count      (fail_count),
        .o_results_checked (results_checked),
        .o_keywords_seen   (keywords_seen)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d result words outstanding.",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The reader switches between styles: always ready, coin flip, a regular
    // pattern timed by pop_tick, and long stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop_tick <= pop_tick + 1;
            if (pop_phase == 0) begin
                pop_style <= $urandom_range(0, 3);
                pop_phase <= $urandom_range(20, 200);
            end else begin
                pop_phase <= pop_phase - 1;
            end
            case (pop_style)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= (pop_tick % 4 == 0);
                default: pop <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic send(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push         <= 1'b1;
        i_opcode     <= op;
        i_byte_value <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
        if (op == OP_END) end_markers++;
    endtask

    task automatic send_blank();
        send(OP_DATA, ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : 8'h20);
        blanks_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send(OP_DATA, s[i]);
    endtask

    task automatic send_end();
        send(OP_END, 8'($urandom_range(0, 255)));
    endtask

    // Hold the input back until every predicted record has been read.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Sends a keyword in random case; a near miss drops the last letter or
    // appends one more word character.
    task automatic send_keyword(input bit near_miss);
        t_kw        e;
        int         n;
        int         how;
        logic [7:0] c;
        e   = kw_entry(5'($urandom_range(0, NUM_KEYWORDS - 1)));
        n   = int'(e.len);
        how = near_miss ? $urandom_range(1, 2) : 0;
        if (how == 1 && n > 1) n--;
        for (int i = 0; i < n; i++) begin
            c = e.text[(int'(e.len) - 1 - i) * 8 +: 8];
            if ($urandom_range(0, 1)) c = c - 8'd32;
            send(OP_DATA, c);
        end
        if (how == 2) send(OP_DATA, pick(word_chars));
    endtask

    task automatic send_string();
        logic [7:0] quote;
        quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        send(OP_DATA, quote);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 5))
                0: begin
                    send(OP_DATA, CH_BSLASH);
                    send(OP_DATA, $urandom_range(0, 1) ? quote : 8'($urandom_range(0, 255)));
                end
                1: send(OP_DATA, (quote == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
                2: send(OP_DATA, 8'($urandom_range(0, 255)));
                3: send(OP_DATA, 8'h20);
                default: send(OP_DATA, pick(word_chars));
            endcase
        end
        if ($urandom_range(0, 6) != 0) send(OP_DATA, quote);
    endtask

    task automatic send_token();
        case ($urandom_range(0, 13))
            0, 1, 2: send_keyword(1'b0);
            3:       send_keyword(1'b1);
            4, 5: begin
                send(OP_DATA, $urandom_range(0, 5) == 0 ? CH_UNDER : pick(word_chars.substr(0, 51)));
                repeat ($urandom_range(0, 13)) send(OP_DATA, pick(word_chars));
            end
            6: begin
                send(OP_DATA, CH_DASH);
                repeat ($urandom_range(0, 5)) send(OP_DATA, pick(flag_chars));
            end
            7, 8: send_string();
            9: begin
                send(OP_DATA, CH_DOT);
                if ($urandom_range(0, 1)) send(OP_DATA, CH_DOT);
            end
            10: send(OP_DATA, CH_SLASH);
            11: send(OP_DATA, CH_STAR);
            12: send(OP_DATA, $urandom_range(0, 1) ? pick(odd_chars)
                                                  : 8'($urandom_range(128, 255)));
            default: send(OP_DATA, 8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Mixed-case keyword, flag with a digit, dot closed by a slash,
        // wildcard, and the two byte extremes as unknown tokens.
        send_text("Files -a9 ./*");
        send(OP_DATA, 8'h00);
        send(OP_DATA, 8'hFF);
        send(OP_END, 8'hFF);
        // Dotdot, then a string whose escaped quote leaves it open at the end.
        send_text(".. \"a\\\"");
        send(OP_END, 8'h00);
        // Escape still pending when the end marker arrives.
        send_text("'x\\");
        send(OP_END, 8'h5A);
        drain();

        while (words_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(1, 6)) begin
                    send_token();
                    if ($urandom_range(0, 4) != 0) repeat ($urandom_range(1, 3)) send_blank();
                end
                if ($urandom_range(0, 3) != 0) send_end();
            end else begin
                repeat ($urandom_range(1, 8))
                    send($urandom_range(0, 9) == 0 ? OP_END : OP_DATA, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 29) == 0) drain();
            if ($urandom_range(0, 19) == 0) gaps_on = !gaps_on;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d input words (%0d blanks, %0d end markers), %0d records checked.",
                 words_sent, blanks_sent, end_markers, results_checked);
        $display("Keyword indexes reported: %0d of %0d.",
                 $countones(keywords_seen), NUM_KEYWORDS);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
